@@ hw/rtl/wes_pkg.sv @@
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types and constants for the 1D wave equation stencil engine.
// ----------------------------------------------------------------------------
package wes_pkg;

   // default grid depth
   localparam int GRID_CELLS_DEFAULT = 128;

   // field widths
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 7;
   localparam int VALUE_W  = 32;
   localparam int LAMBDA_W = 17;
   localparam int CELLS_W  = 8;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 17'd16384;
   localparam logic [LAMBDA_W-1:0] LAMBDA_ONE   = 17'd65536;
   localparam logic [CELLS_W-1:0]  CELLS_RESET  = 8'd100;

   // datapath widths (signed)
   localparam int LAP_W  = 35;   // left - 2*mid + right
   localparam int PROD_W = 53;   // 18-bit signed lambda times Laplacian
   localparam int RND_W  = 38;   // scaled Laplacian
   localparam int BASE_W = 35;   // prev, or 2*cur - prev
   localparam int SUM_W  = 39;   // before saturation

   // cycles from the last sweep issue to the last write
   localparam int PIPE_DRAIN = 4;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_START   = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LAMBDA = 2'd0,
      CSR_CELLS  = 2'd1
   } csr_index_type;

   typedef struct packed {
      op_type                     op;
      logic [INDEX_W-1:0]         cell_index;
      logic signed [VALUE_W-1:0]  load_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  read_value;
      logic                       saturated;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;      // latch the accepted request
      logic load_wr;      // write previous level for a load
      logic sweep_clear;  // clear the saturation flag before a sweep
      logic sweep_issue;  // read one cell of the sweep
      logic rsp_load;     // load the response register
      logic swap;         // exchange level banks after an advance
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
   } status_type;

endpackage

@@ hw/rtl/wes_csr.sv @@
// ----------------------------------------------------------------------------
// wes_csr
// Configuration registers with clamping to the usable ranges.
// ----------------------------------------------------------------------------
module wes_csr
   import wes_pkg::*;
#(
   parameter int GRID_CELLS = GRID_CELLS_DEFAULT,
   localparam int CNT_W = $clog2(GRID_CELLS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [LAMBDA_W-1:0]   lambda_eff,
   output logic [CNT_W-1:0]      cells_eff
);

   localparam int CMP_W = (CNT_W > CELLS_W) ? CNT_W : CELLS_W;

   logic [LAMBDA_W-1:0] lambda_ff;
   logic [CELLS_W-1:0]  cells_ff;
   logic [CMP_W-1:0]    cells_x;
   logic [CMP_W-1:0]    grid_x;
   logic [CMP_W-1:0]    count_x;

   assign csr_ready = 1'b1;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= LAMBDA_RESET;
         cells_ff  <= CELLS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LAMBDA: lambda_ff <= csr_wdata[LAMBDA_W-1:0];
            CSR_CELLS:  cells_ff  <= csr_wdata[CELLS_W-1:0];
            default: ;
         endcase
      end
   end

   // Courant number limited to 1.0
   assign lambda_eff = (lambda_ff > LAMBDA_ONE) ? LAMBDA_ONE : lambda_ff;

   // active count limited to 1..GRID_CELLS
   always_comb begin
      cells_x = CMP_W'(cells_ff);
      grid_x  = CMP_W'(GRID_CELLS);
      if (cells_ff == '0) begin
         count_x = CMP_W'(1);
      end else if (cells_x > grid_x) begin
         count_x = grid_x;
      end else begin
         count_x = cells_x;
      end
   end

   assign cells_eff = count_x[CNT_W-1:0];

endmodule

@@ hw/rtl/wes_ctrl.sv @@
// ----------------------------------------------------------------------------
// wes_ctrl
// Sequencer: decodes one transaction, walks the active cells for start and
// advance, waits for the pipeline to drain and hands over the response.
// ----------------------------------------------------------------------------
module wes_ctrl
   import wes_pkg::*;
#(
   parameter int GRID_CELLS = GRID_CELLS_DEFAULT,
   localparam int CNT_W  = $clog2(GRID_CELLS + 1),
   localparam int ADDR_W = $clog2(GRID_CELLS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [CNT_W-1:0]  cells_eff,
   input  status_type        status,
   output cmd_type           cmd,
   output logic [CNT_W-1:0]  sweep_cnt,
   output logic [ADDR_W-1:0] sweep_addr
);

   localparam int DRAIN_W = $clog2(PIPE_DRAIN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type          state_ff,  state_in;
   logic [CNT_W-1:0]   cnt_ff,    cnt_in;
   logic [DRAIN_W-1:0] drain_ff,  drain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               sweep_op;
   logic               out_free;

   assign sweep_op = (status.op == OP_START) || (status.op == OP_ADVANCE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sweep_op) begin
               cmd.sweep_clear = 1'b1;
               cnt_in          = '0;
               state_in        = ST_SWEEP;
            end else begin
               cmd.load_wr = (status.op == OP_LOAD);
               state_in    = ST_FINISH;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_issue = 1'b1;
            if (cnt_ff == cells_eff) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
            if (drain_ff == DRAIN_W'(PIPE_DRAIN - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.swap     = (status.op == OP_ADVANCE);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign sweep_cnt  = cnt_ff;
   // the tail issue past the last cell reads a harmless address
   assign sweep_addr = (cnt_ff == cells_eff) ? '0 : cnt_ff[ADDR_W-1:0];

endmodule

@@ hw/rtl/wes_dp.sv @@
// ----------------------------------------------------------------------------
// wes_dp
// Datapath: two level banks, stencil window, multiply, rounding and
// saturating update, plus the request and response registers.
// ----------------------------------------------------------------------------
module wes_dp
   import wes_pkg::*;
#(
   parameter int GRID_CELLS = GRID_CELLS_DEFAULT,
   localparam int CNT_W  = $clog2(GRID_CELLS + 1),
   localparam int ADDR_W = $clog2(GRID_CELLS)
) (
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_data,
   output rsp_type             rsp_data,
   input  logic [LAMBDA_W-1:0] lambda_eff,
   input  logic [CNT_W-1:0]    cells_eff,
   input  cmd_type             cmd,
   input  logic [CNT_W-1:0]    sweep_cnt,
   input  logic [ADDR_W-1:0]   sweep_addr,
   output status_type          status
);

   localparam int CMP_W = (CNT_W > CELLS_W) ? CNT_W : CELLS_W;

   // level banks, role given by bank_sel_ff (bank holding the current level)
   logic [VALUE_W-1:0] mem0 [GRID_CELLS];
   logic [VALUE_W-1:0] mem1 [GRID_CELLS];
   logic [VALUE_W-1:0] q0_ff, q1_ff;
   logic               bank_sel_ff;

   req_type            req_ff;
   rsp_type            rsp_ff;
   logic               is_adv, is_start, src_bank;
   logic [CMP_W-1:0]   idx_x;
   logic [ADDR_W-1:0]  idx_addr;
   logic               idx_ok;
   logic [ADDR_W-1:0]  rd_addr;
   logic signed [VALUE_W-1:0] s_q, d_q, cur_q;

   // window and issue tag
   logic               iss_v_ff;
   logic [CNT_W-1:0]   iss_k_ff;
   logic [CNT_W-1:0]   k_minus;
   logic signed [VALUE_W-1:0] win_left_ff, win_mid_ff, d_dly_ff;
   logic               first_c, last_c, v0;

   // pipeline stages
   logic               v1_ff, v2_ff, v3_ff;
   logic [ADDR_W-1:0]  j1_ff, j2_ff, j3_ff;
   logic signed [LAP_W-1:0]  lap_in, lap_ff;
   logic signed [BASE_W-1:0] base_in, base1_ff, base2_ff, base3_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [RND_W-1:0]  rnd_in, rnd_ff;

   logic signed [LAP_W-1:0]  mid_l, left_l, right_l;
   logic signed [BASE_W-1:0] mid_b, d_b;
   logic signed [PROD_W-1:0] half_v, rsum, rshift;
   logic signed [SUM_W-1:0]  base_s, rnd_s, sum_x;
   logic               ovf;
   logic [VALUE_W-1:0] wr_sweep_data;
   logic               sat_ff;

   logic               we0, we1;
   logic [ADDR_W-1:0]  wa;
   logic [VALUE_W-1:0] wd;

   assign status.op = req_ff.op;

   assign is_adv   = (req_ff.op == OP_ADVANCE);
   assign is_start = (req_ff.op == OP_START);
   // start reads previous into current; advance reads current into previous
   assign src_bank = is_adv ? bank_sel_ff : ~bank_sel_ff;

   assign idx_x    = CMP_W'(req_ff.cell_index);
   assign idx_addr = idx_x[ADDR_W-1:0];
   assign idx_ok   = (idx_x < CMP_W'(cells_eff));

   // request register and bank roles
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_sel_ff <= 1'b0;
      end else if (cmd.swap) begin
         bank_sel_ff <= ~bank_sel_ff;
      end
   end

   // memory ports: one shared read address, one write per bank
   assign rd_addr = cmd.sweep_issue ? sweep_addr : idx_addr;

   always_comb begin
      we0 = 1'b0;
      we1 = 1'b0;
      wa  = idx_addr;
      wd  = req_ff.load_value;
      if (cmd.load_wr && idx_ok) begin
         we0 = bank_sel_ff;
         we1 = ~bank_sel_ff;
      end else if (v3_ff) begin
         we0 = src_bank;
         we1 = ~src_bank;
         wa  = j3_ff;
         wd  = wr_sweep_data;
      end
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         mem0[wa] <= wd;
      end
      q0_ff <= mem0[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         mem1[wa] <= wd;
      end
      q1_ff <= mem1[rd_addr];
   end

   assign s_q   = src_bank ? $signed(q1_ff) : $signed(q0_ff);
   assign d_q   = src_bank ? $signed(q0_ff) : $signed(q1_ff);
   assign cur_q = bank_sel_ff ? $signed(q1_ff) : $signed(q0_ff);

   // issue tag lines up with the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_v_ff <= 1'b0;
      end else begin
         iss_v_ff <= cmd.sweep_issue;
      end
   end

   always_ff @(posedge clock) begin
      iss_k_ff <= sweep_cnt;
      if (iss_v_ff) begin
         win_left_ff <= win_mid_ff;
         win_mid_ff  <= s_q;
         d_dly_ff    <= d_q;
      end
   end

   // stencil: cell k-1 once cell k has arrived; walls mirror with sign flip
   assign k_minus = iss_k_ff - CNT_W'(1);
   assign v0      = iss_v_ff && (iss_k_ff != '0);
   assign first_c = (iss_k_ff == CNT_W'(1));
   assign last_c  = (iss_k_ff == cells_eff);

   always_comb begin
      mid_l   = LAP_W'(win_mid_ff);
      left_l  = first_c ? -mid_l : LAP_W'(win_left_ff);
      right_l = last_c  ? -mid_l : LAP_W'(s_q);
      lap_in  = left_l - (mid_l <<< 1) + right_l;
      mid_b   = BASE_W'(win_mid_ff);
      d_b     = BASE_W'(d_dly_ff);
      base_in = is_adv ? ((mid_b <<< 1) - d_b) : mid_b;
   end

   // multiply by the Courant number
   assign prod_in = PROD_W'($signed({1'b0, lambda_eff})) * PROD_W'(lap_ff);

   // round half up: by 2^17 for start, 2^16 for advance
   always_comb begin
      half_v = is_start ? PROD_W'(65536) : PROD_W'(32768);
      rsum   = prod_ff + half_v;
      rshift = is_start ? (rsum >>> 17) : (rsum >>> 16);
      rnd_in = rshift[RND_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v0;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      j1_ff    <= k_minus[ADDR_W-1:0];
      lap_ff   <= lap_in;
      base1_ff <= base_in;
      j2_ff    <= j1_ff;
      prod_ff  <= prod_in;
      base2_ff <= base1_ff;
      j3_ff    <= j2_ff;
      rnd_ff   <= rnd_in;
      base3_ff <= base2_ff;
   end

   // update and clamp to the Q16.16 range
   always_comb begin
      base_s = SUM_W'(base3_ff);
      rnd_s  = SUM_W'(rnd_ff);
      sum_x  = base_s + rnd_s;
      ovf    = !((&sum_x[SUM_W-1:VALUE_W-1]) || !(|sum_x[SUM_W-1:VALUE_W-1]));
      if (ovf) begin
         wr_sweep_data = sum_x[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         wr_sweep_data = sum_x[VALUE_W-1:0];
      end
   end

   // saturation seen during this sweep
   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_clear) begin
         sat_ff <= 1'b0;
      end else if (v3_ff && ovf) begin
         sat_ff <= 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.read_value <= ((req_ff.op == OP_READ) && idx_ok) ? cur_q : '0;
         rsp_ff.saturated  <= (is_start || is_adv) ? sat_ff : 1'b0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ hw/rtl/wave_equation_stencil_1d.sv @@
// ----------------------------------------------------------------------------
// wave_equation_stencil_1d
// Explicit finite-difference engine for the 1D wave equation.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A load or a read passes through the
// decode and finish states before it raises rsp_valid. A start or an advance
// over N active cells sweeps them in between: the sweep reads one cell per
// cycle through the single read port of each level bank, and the multiply,
// rounding and update stages drain before the finish state. The input is
// ready again in the cycle the response appears. Advance swaps the roles of
// the two banks instead of copying. Bank contents are not cleared at reset;
// load the previous level before issuing start. A new transaction is accepted
// while the previous response still waits in the output register.
module wave_equation_stencil_1d
   import wes_pkg::*;
#(
   parameter int GRID_CELLS = GRID_CELLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W  = $clog2(GRID_CELLS + 1);
   localparam int ADDR_W = $clog2(GRID_CELLS);

   logic [LAMBDA_W-1:0] lambda_eff;
   logic [CNT_W-1:0]    cells_eff;
   cmd_type             cmd;
   status_type          status;
   logic [CNT_W-1:0]    sweep_cnt;
   logic [ADDR_W-1:0]   sweep_addr;

   wes_csr #(.GRID_CELLS(GRID_CELLS)) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .lambda_eff (lambda_eff),
      .cells_eff  (cells_eff)
   );

   wes_ctrl #(.GRID_CELLS(GRID_CELLS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cells_eff  (cells_eff),
      .status     (status),
      .cmd        (cmd),
      .sweep_cnt  (sweep_cnt),
      .sweep_addr (sweep_addr)
   );

   wes_dp #(.GRID_CELLS(GRID_CELLS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .rsp_data   (rsp_data),
      .lambda_eff (lambda_eff),
      .cells_eff  (cells_eff),
      .cmd        (cmd),
      .sweep_cnt  (sweep_cnt),
      .sweep_addr (sweep_addr),
      .status     (status)
   );

endmodule

@@ hw/rtl/wes_checker.sv @@
// ----------------------------------------------------------------------------
// wes_checker
// Port-level assertions for the stencil engine, bound to the top level.
// ----------------------------------------------------------------------------
module wes_checker
   import wes_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // only one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a new response only comes out of a busy period
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response without a transaction");

   // idle stays idle without a request
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      req_ready && !req_valid |=> req_ready)
      else $error("left idle without a request");

endmodule

bind wave_equation_stencil_1d wes_checker u_checker (.*);
